/* src/pmst_pkg.sv */
// Shared types and constants for the Prim spanning tree engine.
// Depends on nothing; imported by every module of the block.
package pmst_pkg;

    localparam int MAX_NODES   = 16;
    localparam int WEIGHT_BITS = 16;
    localparam int NODE_W      = $clog2(MAX_NODES);
    localparam int CNT_W       = $clog2(MAX_NODES + 1);
    localparam int KEY_W       = WEIGHT_BITS + 1;
    localparam int ADDR_W      = 2 * NODE_W;
    localparam int DEPTH       = MAX_NODES * MAX_NODES;

    localparam logic [KEY_W-1:0] KEY_INF = {1'b1, {WEIGHT_BITS{1'b0}}};

    // Configuration register indexes.
    localparam logic CFG_NODE_COUNT = 1'b0;
    localparam logic CFG_SOURCE     = 1'b1;

    // Command broadcast from the sequencer to every cell.
    typedef struct packed {
        logic                   init;
        logic [NODE_W-1:0]      src_idx;
        logic                   mark;
        logic [NODE_W-1:0]      mark_idx;
        logic                   relax;
        logic [NODE_W-1:0]      relax_idx;
        logic [NODE_W-1:0]      relax_from;
        logic                   relax_ev;
        logic [WEIGHT_BITS-1:0] relax_w;
        logic [CNT_W-1:0]       cnt;
    } t_cell_cmd;

    // Running minimum handed along the chain.
    typedef struct packed {
        logic              found;
        logic [KEY_W-1:0]  low;
        logic [NODE_W-1:0] idx;
    } t_chain;

    // State one cell exposes for the result phase.
    typedef struct packed {
        logic              in_tree;
        logic              pvalid;
        logic [NODE_W-1:0] parent;
        logic [KEY_W-1:0]  key;
    } t_cell_state;

endpackage

/* src/prim_minimum_spanning_tree.sv */
// Prim minimum spanning tree engine: top level with sequencer and result port.
// Depends on pmst_pkg, pmst_edge_ram and pmst_cell.
//
// Edges are taken one transaction per cycle while not stalled and are folded
// into a weight matrix, keeping the lower weight of a repeated edge. The
// transaction marked last_edge starts a run: a setup state, then for each node
// joined a search through the chain of node cells plus a relax sweep reading
// one matrix row entry per cycle, and a final search that finds nothing. Then
// one result transaction per node follows in node order, at most one per
// cycle, and the matrix valid bits are cleared. Input stall stays high from
// the last edge until the clear is done.
// Configuration writes are always ready and should be issued only while idle.
module prim_minimum_spanning_tree
    import pmst_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [4:0]  i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [3:0]  i_end_a,
    input  logic [3:0]  i_end_b,
    input  logic [15:0] i_edge_weight,
    input  logic        i_last_edge,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [3:0]  o_node_id,
    output logic [3:0]  o_parent_id,
    output logic        o_has_parent,
    output logic [15:0] o_link_weight,
    output logic        o_reached,
    output logic        o_last_node
);

    typedef enum logic [6:0] {
        S_LOAD   = 7'b0000001,
        S_INIT   = 7'b0000010,
        S_SEARCH = 7'b0000100,
        S_RELAX  = 7'b0001000,
        S_OUTPUT = 7'b0010000,
        S_CLEAR  = 7'b0100000,
        S_SPARE  = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    // Configuration registers.
    logic [4:0] r_cfg_cnt;
    logic [3:0] r_cfg_src;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_cnt <= 5'd16;
            r_cfg_src <= 4'd0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_NODE_COUNT: r_cfg_cnt <= i_cfg_data;
                CFG_SOURCE:     r_cfg_src <= i_cfg_data[3:0];
                default:        r_cfg_cnt <= r_cfg_cnt;
            endcase
        end
    end

    // Effective count and source, latched at the start of a run.
    logic [CNT_W-1:0]  r_cnt;
    logic [NODE_W-1:0] r_src;
    logic [CNT_W-1:0]  w_cnt_sat;
    logic [NODE_W-1:0] w_src_eff;

    always_comb begin
        if (r_cfg_cnt < 5'd2) begin
            w_cnt_sat = CNT_W'(2);
        end else if (32'(r_cfg_cnt) > MAX_NODES) begin
            w_cnt_sat = CNT_W'(MAX_NODES);
        end else begin
            w_cnt_sat = CNT_W'(r_cfg_cnt);
        end
        w_src_eff = (32'(r_cfg_src) < 32'(w_cnt_sat)) ? NODE_W'(r_cfg_src) : '0;
    end

    // Edge store: read at acceptance, compare and write in the following cycle.
    // The matrix keeps each undirected edge once, at (lower, higher) endpoint.
    logic                   w_in_acc;
    logic [NODE_W-1:0]      w_lo, w_hi;
    logic                   w_in_ok;
    logic                   r_s1_v;
    logic [ADDR_W-1:0]      r_s1_addr;
    logic [WEIGHT_BITS-1:0] r_s1_w;
    logic                   r_hit;
    logic [WEIGHT_BITS-1:0] r_hit_w;
    logic                   w_old_v;
    logic [WEIGHT_BITS-1:0] w_old_w;
    logic                   w_wr_en;
    logic [ADDR_W-1:0]      w_in_addr;
    logic [ADDR_W-1:0]      w_rd_addr;
    logic [WEIGHT_BITS-1:0] w_rd_data;
    logic                   w_rd_valid;

    assign o_in_stall = (r_state != S_LOAD);
    assign w_in_acc   = i_in_valid && !o_in_stall;

    always_comb begin
        w_in_ok = (32'(i_end_a) < MAX_NODES) && (32'(i_end_b) < MAX_NODES)
                  && (i_end_a != i_end_b);
        if (i_end_a < i_end_b) begin
            w_lo = NODE_W'(i_end_a);
            w_hi = NODE_W'(i_end_b);
        end else begin
            w_lo = NODE_W'(i_end_b);
            w_hi = NODE_W'(i_end_a);
        end
        w_in_addr = {w_lo, w_hi};
    end

    // A write in flight to the same entry is forwarded over the stale read.
    assign w_old_v = r_hit || w_rd_valid;
    assign w_old_w = r_hit ? r_hit_w : w_rd_data;
    assign w_wr_en = r_s1_v && (!w_old_v || (r_s1_w < w_old_w));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else begin
            r_s1_v <= w_in_acc && w_in_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_addr <= w_in_addr;
        r_s1_w    <= WEIGHT_BITS'(i_edge_weight);
        r_hit     <= w_wr_en && (r_s1_addr == w_in_addr);
        r_hit_w   <= r_s1_w;
    end

    // Run sequencer.
    logic [CNT_W-1:0]  r_step;
    logic [NODE_W-1:0] r_u;
    logic              r_rx_v;
    logic [NODE_W-1:0] r_rx_k;
    logic [NODE_W-1:0] w_k;
    logic [NODE_W-1:0] w_rlo, w_rhi;
    t_cell_cmd         w_cmd;
    t_chain            w_chain [MAX_NODES+1];
    t_cell_state       w_cell [MAX_NODES];
    t_chain            w_tail;
    logic              w_search_done;
    logic              w_out_free;
    logic              w_clear;

    assign w_tail        = w_chain[MAX_NODES];
    assign w_search_done = (r_state == S_SEARCH) && (32'(r_step) == MAX_NODES);
    assign w_k           = r_step[NODE_W-1:0];

    always_comb begin
        if (r_u < w_k) begin
            w_rlo = r_u;
            w_rhi = w_k;
        end else begin
            w_rlo = w_k;
            w_rhi = r_u;
        end
        w_rd_addr = (r_state == S_RELAX) ? {w_rlo, w_rhi} : w_in_addr;
    end

    always_comb begin
        w_cmd.init       = (r_state == S_INIT);
        w_cmd.src_idx    = r_src;
        w_cmd.mark       = w_search_done && w_tail.found;
        w_cmd.mark_idx   = w_tail.idx;
        w_cmd.relax      = r_rx_v;
        w_cmd.relax_idx  = r_rx_k;
        w_cmd.relax_from = r_u;
        w_cmd.relax_ev   = w_rd_valid;
        w_cmd.relax_w    = w_rd_data;
        w_cmd.cnt        = r_cnt;
    end

    assign w_chain[0] = '{found: 1'b0, low: KEY_INF, idx: '0};

    for (genvar g = 0; g < MAX_NODES; g++) begin : g_cell
        pmst_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_idx   (NODE_W'(g)),
            .i_cmd   (w_cmd),
            .i_chain (w_chain[g]),
            .o_chain (w_chain[g+1]),
            .o_state (w_cell[g])
        );
    end

    // Result register: a new result loads when the old one is gone or taken.
    logic              r_ov;
    logic [3:0]        r_node_id;
    logic [3:0]        r_parent_id;
    logic              r_has_parent;
    logic [15:0]       r_link_weight;
    logic              r_reached;
    logic              r_last_node;
    t_cell_state       w_sel;
    logic [NODE_W-1:0] w_v;
    logic              w_hp;
    logic              w_emit;

    assign w_out_free = !r_ov || !i_out_stall;
    assign w_v        = r_step[NODE_W-1:0];
    assign w_sel      = w_cell[w_v];
    assign w_hp       = w_sel.in_tree && w_sel.pvalid && (w_v != r_src);
    assign w_emit     = (r_state == S_OUTPUT) && w_out_free && (r_step < r_cnt);
    assign w_clear    = (r_state == S_CLEAR);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_LOAD:   if (w_in_acc && i_last_edge) n_state = S_INIT;
            S_INIT:   n_state = S_SEARCH;
            S_SEARCH: if (w_search_done) n_state = w_tail.found ? S_RELAX : S_OUTPUT;
            S_RELAX:  if (r_step == r_cnt) n_state = S_SEARCH;
            S_OUTPUT: if (w_out_free && (r_step == r_cnt)) n_state = S_CLEAR;
            S_CLEAR:  n_state = S_LOAD;
            default:  n_state = S_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_step  <= '0;
            r_rx_v  <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_rx_v  <= (r_state == S_RELAX) && (r_step < r_cnt);
            if (r_state != n_state) begin
                r_step <= '0;
            end else if (r_state == S_SEARCH || r_state == S_RELAX || w_emit) begin
                r_step <= r_step + CNT_W'(1);
            end
            if (w_emit) begin
                r_ov <= 1'b1;
            end else if (!i_out_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rx_k <= w_k;
        if (r_state == S_LOAD) begin
            r_cnt <= w_cnt_sat;
            r_src <= w_src_eff;
        end
        if (w_search_done) begin
            r_u <= w_tail.idx;
        end
        if (w_emit) begin
            r_node_id     <= 4'(w_v);
            r_parent_id   <= w_hp ? 4'(w_sel.parent) : 4'd0;
            r_has_parent  <= w_hp;
            r_link_weight <= w_hp ? 16'(w_sel.key) : 16'd0;
            r_reached     <= w_sel.in_tree;
            r_last_node   <= (r_step + CNT_W'(1)) == r_cnt;
        end
    end

    pmst_edge_ram u_ram (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_clear    (w_clear),
        .i_wr_en    (w_wr_en),
        .i_wr_addr  (r_s1_addr),
        .i_wr_data  (r_s1_w),
        .i_rd_addr  (w_rd_addr),
        .o_rd_data  (w_rd_data),
        .o_rd_valid (w_rd_valid)
    );

    assign o_out_valid   = r_ov;
    assign o_node_id     = r_node_id;
    assign o_parent_id   = r_parent_id;
    assign o_has_parent  = r_has_parent;
    assign o_link_weight = r_link_weight;
    assign o_reached     = r_reached;
    assign o_last_node   = r_last_node;

endmodule

/* src/pmst_edge_ram.sv */
// Weight matrix store: a weight memory plus one valid flop per entry.
// Depends on pmst_pkg.
module pmst_edge_ram
    import pmst_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_clear,
    input  logic                   i_wr_en,
    input  logic [ADDR_W-1:0]      i_wr_addr,
    input  logic [WEIGHT_BITS-1:0] i_wr_data,
    input  logic [ADDR_W-1:0]      i_rd_addr,
    output logic [WEIGHT_BITS-1:0] o_rd_data,
    output logic                   o_rd_valid
);

    logic [WEIGHT_BITS-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0]       r_vld;
    logic [WEIGHT_BITS-1:0] r_rd;
    logic                   r_rd_v;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd   <= r_mem[i_rd_addr];
        r_rd_v <= r_vld[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_vld <= '0;
        end else if (i_wr_en) begin
            r_vld[i_wr_addr] <= 1'b1;
        end
    end

    assign o_rd_data  = r_rd;
    assign o_rd_valid = r_rd_v;

endmodule

/* src/pmst_cell.sv */
// One node cell: tree flag, key and parent, plus one stage of the minimum chain.
// Depends on pmst_pkg.
module pmst_cell
    import pmst_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [NODE_W-1:0] i_idx,
    input  t_cell_cmd         i_cmd,
    input  t_chain            i_chain,
    output t_chain            o_chain,
    output t_cell_state       o_state
);

    logic              r_in_tree;
    logic              r_pvalid;
    logic [NODE_W-1:0] r_parent;
    logic [KEY_W-1:0]  r_key;
    t_chain            r_chain;
    logic              w_active;
    logic              w_take;
    logic              w_relax;

    assign w_active = CNT_W'(i_idx) < i_cmd.cnt;
    assign w_take   = w_active && !r_in_tree && (r_key < i_chain.low);
    assign w_relax  = i_cmd.relax && (i_cmd.relax_idx == i_idx) && i_cmd.relax_ev
                      && !r_in_tree && (KEY_W'(i_cmd.relax_w) < r_key);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_tree <= 1'b0;
            r_pvalid  <= 1'b0;
            r_parent  <= '0;
            r_key     <= KEY_INF;
        end else if (i_cmd.init) begin
            r_in_tree <= 1'b0;
            r_pvalid  <= 1'b0;
            r_parent  <= '0;
            r_key     <= (i_idx == i_cmd.src_idx) ? '0 : KEY_INF;
        end else if (i_cmd.mark && (i_cmd.mark_idx == i_idx)) begin
            r_in_tree <= 1'b1;
        end else if (w_relax) begin
            r_key    <= KEY_W'(i_cmd.relax_w);
            r_parent <= i_cmd.relax_from;
            r_pvalid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_chain <= '{found: 1'b1, low: r_key, idx: i_idx};
        end else begin
            r_chain <= i_chain;
        end
    end

    assign o_chain = r_chain;
    assign o_state = '{in_tree: r_in_tree, pvalid: r_pvalid, parent: r_parent, key: r_key};

endmodule
